### rtl/core/dmxr_pkg.sv
// Shared constants, register codes and types for the DMX receiver with PWM outputs.
`timescale 1ns / 1ps

package dmxr_pkg;

	localparam int LAST_SLOT = 7;
	localparam int PWM_BITS = 8;
	localparam int LEVEL_W = 8;
	localparam int CFG_W = 3;
	localparam int CFG_IDX_W = 2;
	localparam int SLOT_W = $clog2(LAST_SLOT + 1);
	localparam int CMP_W = (SLOT_W > CFG_W) ? SLOT_W : CFG_W;
	localparam int PWM_CMP_W = (PWM_BITS > LEVEL_W) ? PWM_BITS : LEVEL_W;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_BYTE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_SERVO2_SLOT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RED_SLOT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GREEN_SLOT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BLUE_SLOT = 2'd3;

	localparam logic [CFG_W-1:0] SERVO2_SLOT_RST = 3'd2;
	localparam logic [CFG_W-1:0] RED_SLOT_RST = 3'd4;
	localparam logic [CFG_W-1:0] GREEN_SLOT_RST = 3'd5;
	localparam logic [CFG_W-1:0] BLUE_SLOT_RST = 3'd6;

	localparam logic [LEVEL_W-1:0] SERVO1_RST = 8'd190;
	localparam logic [LEVEL_W-1:0] SERVO2_RST = 8'd200;

	typedef struct packed {
		logic [LEVEL_W-1:0] red;
		logic [LEVEL_W-1:0] green;
		logic [LEVEL_W-1:0] blue;
		logic [LEVEL_W-1:0] servo_one;
		logic [LEVEL_W-1:0] servo_two;
	} levels_t;

	typedef struct packed {
		logic red;
		logic green;
		logic blue;
		logic servo_one;
		logic servo_two;
	} pwm_bits_t;

	typedef struct packed {
		logic byte_en;
		logic tick_en;
	} step_t;

endpackage

### rtl/core/dmx_receiver_five_channel_pwm.sv
// Top level: DMX512 receiver driving three LED and two servo PWM outputs.
// Input channel (in_valid / in_stall): one item per event. cmd selects a
// PWM timer tick or a received serial byte (rx_byte, framing_error).
// Output channel (out_valid / out_stall): one item per input item, carrying
// the five output levels as they stand after that input item.
// Configuration: cfg_wr_en writes cfg_data into the slot register at
// cfg_index (servo2, red, green, blue slot numbers); write only while idle.
// An accepted item passes the input register, then the frame decoder and
// PWM compare that load the output register. Throughput is one item per
// cycle while out_stall does not hold a waiting result.
// While out_stall holds a waiting result, one more item may sit in the
// input register; after that in_stall rises in the same cycle.
// Reset clears the pipeline, sets the slot registers to 2, 4, 5 and 6, the
// color levels to 0, the servo levels to 190 and 200, the PWM counter to 0
// and all outputs low, with reception idle until the next break.
`timescale 1ns / 1ps

module dmx_receiver_five_channel_pwm import dmxr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 cmd,
	input  logic [7:0]           rx_byte,
	input  logic                 framing_error,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 red_out,
	output logic                 green_out,
	output logic                 blue_out,
	output logic                 servo_one_out,
	output logic                 servo_two_out
);

	logic       valid_s1;
	logic       cmd_s1;
	logic [7:0] rx_byte_s1;
	logic       ferr_s1;
	logic       out_valid_q;
	logic       advance;
	step_t      step;
	levels_t    levels;
	pwm_bits_t  pwm_bits;

	assign advance = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign step.byte_en = valid_s1 && advance && (cmd_s1 == CMD_BYTE);
	assign step.tick_en = valid_s1 && advance && (cmd_s1 == CMD_TICK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1 <= cmd;
			rx_byte_s1 <= rx_byte;
			ferr_s1 <= framing_error;
		end
	end

	dmxr_rx u_rx (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.step          (step),
		.rx_byte       (rx_byte_s1),
		.framing_error (ferr_s1),
		.levels        (levels)
	);

	dmxr_pwm u_pwm (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.levels   (levels),
		.pwm_bits (pwm_bits)
	);

	assign out_valid = out_valid_q;
	assign red_out = pwm_bits.red;
	assign green_out = pwm_bits.green;
	assign blue_out = pwm_bits.blue;
	assign servo_one_out = pwm_bits.servo_one;
	assign servo_two_out = pwm_bits.servo_two;

endmodule

### rtl/core/dmxr_rx.sv
// DMX frame decoder: break/start-code tracking, slot counting and level registers.
`timescale 1ns / 1ps

module dmxr_rx import dmxr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  step_t                step,
	input  logic [7:0]           rx_byte,
	input  logic                 framing_error,
	output levels_t              levels
);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_BREAK = 2'd1;
	localparam logic [1:0] PH_START = 2'd2;
	localparam logic [1:0] PH_DATA = 2'd3;

	logic [CFG_W-1:0]  servo2_slot_q;
	logic [CFG_W-1:0]  red_slot_q;
	logic [CFG_W-1:0]  green_slot_q;
	logic [CFG_W-1:0]  blue_slot_q;
	logic [1:0]        phase_q;
	logic [1:0]        phase_d;
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] slot_d;
	logic [SLOT_W-1:0] slot_step;
	levels_t           levels_q;
	levels_t           levels_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			servo2_slot_q <= SERVO2_SLOT_RST;
			red_slot_q <= RED_SLOT_RST;
			green_slot_q <= GREEN_SLOT_RST;
			blue_slot_q <= BLUE_SLOT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_SERVO2_SLOT: servo2_slot_q <= cfg_data;
				REG_RED_SLOT: red_slot_q <= cfg_data;
				REG_GREEN_SLOT: green_slot_q <= cfg_data;
				REG_BLUE_SLOT: blue_slot_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign slot_step = (slot_q < SLOT_W'(LAST_SLOT)) ? slot_q + SLOT_W'(1) : slot_q;

	always_comb begin
		phase_d = phase_q;
		slot_d = slot_q;
		levels_d = levels_q;
		if (step.byte_en) begin
			if (framing_error) begin
				slot_d = SLOT_W'(1);
				phase_d = PH_BREAK;
			end else begin
				case (phase_q)
					PH_BREAK: begin
						phase_d = (rx_byte == 8'd0) ? PH_START : PH_IDLE;
					end
					PH_START: begin
						slot_d = SLOT_W'(1);
						levels_d.servo_one = rx_byte;
						phase_d = PH_DATA;
					end
					PH_DATA: begin
						slot_d = slot_step;
						if (CMP_W'(slot_step) == CMP_W'(servo2_slot_q)) begin
							levels_d.servo_two = rx_byte;
						end
						if (CMP_W'(slot_step) == CMP_W'(red_slot_q)) begin
							levels_d.red = rx_byte;
						end
						if (CMP_W'(slot_step) == CMP_W'(green_slot_q)) begin
							levels_d.green = rx_byte;
						end
						if (CMP_W'(slot_step) == CMP_W'(blue_slot_q)) begin
							levels_d.blue = rx_byte;
						end
						if (slot_step >= SLOT_W'(LAST_SLOT)) begin
							phase_d = PH_IDLE;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			slot_q <= '0;
			levels_q.red <= '0;
			levels_q.green <= '0;
			levels_q.blue <= '0;
			levels_q.servo_one <= SERVO1_RST;
			levels_q.servo_two <= SERVO2_RST;
		end else begin
			phase_q <= phase_d;
			slot_q <= slot_d;
			levels_q <= levels_d;
		end
	end

	assign levels = levels_q;

endmodule

### rtl/core/dmxr_pwm.sv
// PWM counter and level compare; holds the five output bits between ticks.
`timescale 1ns / 1ps

module dmxr_pwm import dmxr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  step_t     step,
	input  levels_t   levels,
	output pwm_bits_t pwm_bits
);

	logic [PWM_BITS-1:0] cnt_q;
	pwm_bits_t           bits_q;
	pwm_bits_t           bits_d;

	always_comb begin
		bits_d.red = PWM_CMP_W'(cnt_q) <= PWM_CMP_W'(levels.red);
		bits_d.green = PWM_CMP_W'(cnt_q) <= PWM_CMP_W'(levels.green);
		bits_d.blue = PWM_CMP_W'(cnt_q) <= PWM_CMP_W'(levels.blue);
		bits_d.servo_one = PWM_CMP_W'(cnt_q) <= PWM_CMP_W'(levels.servo_one);
		bits_d.servo_two = PWM_CMP_W'(cnt_q) <= PWM_CMP_W'(levels.servo_two);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			bits_q <= '0;
		end else if (step.tick_en) begin
			cnt_q <= cnt_q + PWM_BITS'(1);
			bits_q <= bits_d;
		end
	end

	assign pwm_bits = bits_q;

endmodule

### rtl/core/dmxr_checker.sv
// Port-level checker for the DMX receiver top level, attached by bind.
`timescale 1ns / 1ps

module dmxr_checker import dmxr_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 cfg_wr_en,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_W-1:0]     cfg_data,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 cmd,
	input logic [7:0]           rx_byte,
	input logic                 framing_error,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic                 red_out,
	input logic                 green_out,
	input logic                 blue_out,
	input logic                 servo_one_out,
	input logic                 servo_two_out
);

	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output item dropped while stalled");

	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable({red_out, green_out, blue_out,
			servo_one_out, servo_two_out}))
		else $error("stalled output item changed");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled output item");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall |=> out_valid)
		else $error("accepted item not delivered after two cycles");

endmodule

bind dmx_receiver_five_channel_pwm dmxr_checker u_dmxr_checker (.*);

### bench/dmxr_pwm_checker.sv
// Checker for the DMX receiver: predicts the five PWM output levels per item and compares them.
`timescale 1ns / 1ps

module dmxr_pwm_checker import dmxr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic                 cmd,
	input  logic [7:0]           rx_byte,
	input  logic                 framing_error,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic                 red_out,
	input  logic                 green_out,
	input  logic                 blue_out,
	input  logic                 servo_one_out,
	input  logic                 servo_two_out,
	output int                   fail_count,
	output int                   expected_left
);

	typedef enum logic [1:0] {RX_IDLE, RX_BREAK, RX_START, RX_DATA} rx_phase_t;

	rx_phase_t           rx_phase;
	logic [SLOT_W-1:0]   slot_no;
	logic [CFG_W-1:0]    slot_sel [4];
	levels_t             level;
	logic [PWM_BITS-1:0] tick_ctr;
	pwm_bits_t           pwm_now;
	pwm_bits_t           levels_due [$];
	string               field_name [5] = '{"servo_two_out", "servo_one_out", "blue_out",
		"green_out", "red_out"};

	task automatic take_serial_byte(input logic [7:0] b, input logic fe);
		if (fe) begin
			slot_no = SLOT_W'(1);
			rx_phase = RX_BREAK;
		end else begin
			case (rx_phase)
				RX_BREAK: begin
					rx_phase = (b == 8'd0) ? RX_START : RX_IDLE;
				end
				RX_START: begin
					slot_no = SLOT_W'(1);
					level.servo_one = b;
					rx_phase = RX_DATA;
				end
				RX_DATA: begin
					if (slot_no < LAST_SLOT)
						slot_no = slot_no + 1'b1;
					if (slot_no == slot_sel[REG_SERVO2_SLOT])
						level.servo_two = b;
					if (slot_no == slot_sel[REG_RED_SLOT])
						level.red = b;
					if (slot_no == slot_sel[REG_GREEN_SLOT])
						level.green = b;
					if (slot_no == slot_sel[REG_BLUE_SLOT])
						level.blue = b;
					if (slot_no >= LAST_SLOT)
						rx_phase = RX_IDLE;
				end
				default: ;
			endcase
		end
	endtask

	task automatic pwm_tick();
		pwm_now.red = (tick_ctr <= level.red);
		pwm_now.green = (tick_ctr <= level.green);
		pwm_now.blue = (tick_ctr <= level.blue);
		pwm_now.servo_one = (tick_ctr <= level.servo_one);
		pwm_now.servo_two = (tick_ctr <= level.servo_two);
		tick_ctr = tick_ctr + 1'b1;
	endtask

	always @(posedge clk) begin
		pwm_bits_t want;
		pwm_bits_t got;
		if (!arst_n) begin
			rx_phase = RX_IDLE;
			slot_no = '0;
			slot_sel[REG_SERVO2_SLOT] = SERVO2_SLOT_RST;
			slot_sel[REG_RED_SLOT] = RED_SLOT_RST;
			slot_sel[REG_GREEN_SLOT] = GREEN_SLOT_RST;
			slot_sel[REG_BLUE_SLOT] = BLUE_SLOT_RST;
			level = '0;
			level.servo_one = SERVO1_RST;
			level.servo_two = SERVO2_RST;
			tick_ctr = '0;
			pwm_now = '0;
			levels_due.delete();
			fail_count = 0;
		end else begin
			if (cfg_wr_en)
				slot_sel[cfg_index] = cfg_data;
			if (out_valid && !out_stall) begin
				got = {red_out, green_out, blue_out, servo_one_out, servo_two_out};
				if (levels_due.size() == 0) begin
					$error("result item with none expected: %b", got);
					fail_count++;
				end else begin
					want = levels_due.pop_front();
					for (int i = 0; i < 5; i++) begin
						if (want[i] !== got[i]) begin
							$error("%s: expected %0b, got %0b", field_name[i], want[i], got[i]);
							fail_count++;
						end
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (cmd == CMD_BYTE)
					take_serial_byte(rx_byte, framing_error);
				else
					pwm_tick();
				levels_due.push_back(pwm_now);
			end
		end
		expected_left = levels_due.size();
	end

endmodule

### bench/tb_dmx_receiver_five_channel_pwm.sv
// Testbench top: drives DMX frames, PWM ticks and slot settings into the receiver and gives the verdict.
`timescale 1ns / 1ps

module tb_dmx_receiver_five_channel_pwm;
	import dmxr_pkg::*;

	localparam int RUN_LIMIT = 600000;
	localparam int PHASES = 6;
	localparam int ITEMS_PER_PHASE = 200;
	localparam int HOLD_CYCLES = 180;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic                 cmd;
	logic [7:0]           rx_byte;
	logic                 framing_error;
	logic                 out_valid;
	logic                 out_stall;
	logic                 red_out;
	logic                 green_out;
	logic                 blue_out;
	logic                 servo_one_out;
	logic                 servo_two_out;

	int fail_count;
	int expected_left;
	int cycle_count;
	int items_sent;
	int sender_idle_pct;
	int stall_pct;
	int hold_reqs;

	dmx_receiver_five_channel_pwm uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.rx_byte(rx_byte),
		.framing_error(framing_error),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.red_out(red_out),
		.green_out(green_out),
		.blue_out(blue_out),
		.servo_one_out(servo_one_out),
		.servo_two_out(servo_two_out)
	);

	dmxr_pwm_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.rx_byte(rx_byte),
		.framing_error(framing_error),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.red_out(red_out),
		.green_out(green_out),
		.blue_out(blue_out),
		.servo_one_out(servo_one_out),
		.servo_two_out(servo_two_out),
		.fail_count(fail_count),
		.expected_left(expected_left)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// receiver side: random stall, or a long hold-off on request
	initial begin
		int holds_done;
		holds_done = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_done < hold_reqs) begin
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				holds_done++;
			end
			out_stall = (stall_pct > 0) && ($urandom_range(99) < stall_pct);
		end
	end

	function automatic logic [7:0] draw_level();
		case ($urandom_range(5))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// call at a falling edge; returns at the falling edge after acceptance
	task automatic send_item(input logic c, input logic [7:0] b, input logic fe);
		if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		in_valid = 1'b1;
		cmd = c;
		rx_byte = b;
		framing_error = fe;
		do @(posedge clk); while (in_stall);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_tick();
		send_item(CMD_TICK, 8'($urandom), 1'($urandom));
	endtask

	task automatic send_frame();
		int n_data;
		logic fe;
		send_item(CMD_BYTE, 8'($urandom), 1'b1);
		if ($urandom_range(9) == 0)
			send_item(CMD_BYTE, 8'($urandom_range(1, 255)), 1'b0);
		else
			send_item(CMD_BYTE, 8'h00, 1'b0);
		n_data = $urandom_range(0, 9);
		for (int i = 0; i < n_data; i++) begin
			if ($urandom_range(3) == 0)
				send_tick();
			fe = ($urandom_range(24) == 0);
			send_item(CMD_BYTE, draw_level(), fe);
		end
		repeat ($urandom_range(0, 40)) send_tick();
		if ($urandom_range(7) == 0)
			send_item(CMD_BYTE, 8'($urandom), 1'($urandom));
	endtask

	task automatic drain();
		in_valid = 1'b0;
		wait (expected_left == 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_slot(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	initial begin
		logic [CFG_W-1:0] plan [PHASES][4];
		int phase_end;
		plan[0] = '{3'd2, 3'd4, 3'd5, 3'd6};
		plan[1] = '{3'd0, 3'd0, 3'd0, 3'd0};
		plan[2] = '{3'd7, 3'd7, 3'd7, 3'd7};
		plan[3] = '{3'd3, 3'd7, 3'd2, 3'd6};
		plan[4] = '{3'd1, 3'd2, 3'd2, 3'd5};
		for (int r = 0; r < 4; r++)
			plan[5][r] = 3'($urandom);
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_SERVO2_SLOT;
		cfg_data = '0;
		in_valid = 1'b0;
		cmd = CMD_TICK;
		rx_byte = '0;
		framing_error = 1'b0;
		hold_reqs = 0;
		sender_idle_pct = 0;
		stall_pct = 0;
		items_sent = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_item(CMD_TICK, 8'hFF, 1'b1);
		send_tick();
		send_item(CMD_BYTE, 8'h00, 1'b0);
		send_item(CMD_BYTE, 8'hFF, 1'b1);
		send_item(CMD_BYTE, 8'h55, 1'b0);
		send_item(CMD_BYTE, 8'h12, 1'b0);
		send_item(CMD_BYTE, 8'h00, 1'b1);
		send_item(CMD_BYTE, 8'h00, 1'b0);
		send_item(CMD_BYTE, 8'hFF, 1'b0);
		send_item(CMD_BYTE, 8'hFF, 1'b0);
		send_item(CMD_BYTE, 8'h00, 1'b0);
		send_item(CMD_BYTE, 8'hFF, 1'b0);
		send_item(CMD_BYTE, 8'h80, 1'b0);
		send_item(CMD_BYTE, 8'h01, 1'b0);
		send_item(CMD_BYTE, 8'h7E, 1'b0);
		send_item(CMD_BYTE, 8'hAA, 1'b0);
		send_tick();
		send_tick();
		send_item(CMD_BYTE, 8'h3C, 1'b1);
		send_item(CMD_BYTE, 8'h00, 1'b0);
		send_item(CMD_BYTE, 8'h00, 1'b0);
		send_item(CMD_BYTE, 8'h10, 1'b0);
		send_item(CMD_BYTE, 8'h20, 1'b1);
		send_item(CMD_BYTE, 8'h00, 1'b0);
		send_tick();

		for (int p = 0; p < PHASES; p++) begin
			drain();
			write_slot(REG_SERVO2_SLOT, plan[p][0]);
			write_slot(REG_RED_SLOT, plan[p][1]);
			write_slot(REG_GREEN_SLOT, plan[p][2]);
			write_slot(REG_BLUE_SLOT, plan[p][3]);
			case (p % 4)
				0: begin sender_idle_pct = 0; stall_pct = 0; end
				1: begin sender_idle_pct = 71; stall_pct = 0; end
				2: begin sender_idle_pct = 0; stall_pct = 71; end
				default: begin sender_idle_pct = 37; stall_pct = 37; end
			endcase
			if (p == 2 || p == 4) begin
				// fill the pipeline against a long hold-off
				hold_reqs++;
				repeat (20) send_tick();
			end
			phase_end = items_sent + ITEMS_PER_PHASE;
			while (items_sent < phase_end)
				send_frame();
		end

		drain();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
